### rtl/mhs_pkg.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner package
// Shared widths, constants and the stage control type of the scanner.
// ----------------------------------------------------------------------------
package mhs_pkg;

   localparam int MOTIF_LEN     = 6;
   localparam int MAX_SEQ_LEN   = 4096;
   localparam int MAX_SEQUENCES = 256;

   localparam int BASE_W  = 3;
   localparam int CODE_W  = 2;
   localparam int DIST_W  = 3;
   localparam int POS_W   = 12;
   localparam int MOTIF_W = CODE_W * MOTIF_LEN;
   localparam int TOTAL_W = 11;
   localparam int COUNT_W = $clog2(MAX_SEQ_LEN + 1);

   localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(MOTIF_LEN * MAX_SEQUENCES);
   localparam logic [DIST_W-1:0]  NO_WINDOW_DIST = DIST_W'(MOTIF_LEN);

   typedef logic [BASE_W-1:0]  base_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [DIST_W-1:0]  dist_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [MOTIF_W-1:0] motif_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic win;
      logic seq_end;
      logic set_end;
   } stage_ctrl_type;

endpackage

### rtl/mhs_cell.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner window cell
// Holds one base of the window, passes it to its neighbor on each shift and
// flags whether the held base mismatches its pattern base.
// ----------------------------------------------------------------------------
module mhs_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  mhs_pkg::base_type base_in,
   input  mhs_pkg::code_type want,
   output mhs_pkg::base_type base_out,
   output mhs_pkg::code_type code_out,
   output logic              mismatch
);

   mhs_pkg::base_type base_ff;
   mhs_pkg::base_type base_in_w;

   always_comb begin
      base_in_w = base_ff;
      if (shift_en) begin
         base_in_w = base_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in_w;
   end

   assign base_out = base_ff;
   assign code_out = base_ff[2] ? mhs_pkg::code_type'(0) : base_ff[1:0];
   assign mismatch = base_ff[2] || (base_ff[1:0] != want);

endmodule

### rtl/mhs_tracker.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner best-window tracker
// Counts window mismatches, keeps the best window of the sequence and the
// saturating set total, and holds the result word in the output register.
// ----------------------------------------------------------------------------
module mhs_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  mhs_pkg::stage_ctrl_type        ctrl,
   input  mhs_pkg::pos_type               pos,
   input  logic [mhs_pkg::MOTIF_LEN-1:0]  mism,
   input  mhs_pkg::motif_type             motif,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output mhs_pkg::dist_type              rsp_best_distance,
   output mhs_pkg::pos_type               rsp_best_position,
   output mhs_pkg::motif_type             rsp_best_motif,
   output mhs_pkg::total_type             rsp_total_distance,
   output logic                           rsp_found,
   output logic                           rsp_last
);

   mhs_pkg::dist_type  min_ff, min_in;
   mhs_pkg::pos_type   mpos_ff, mpos_in;
   mhs_pkg::motif_type mmot_ff, mmot_in;
   logic               seen_ff, seen_in;
   mhs_pkg::total_type total_ff, total_in;

   logic               ovalid_ff, ovalid_in;
   mhs_pkg::dist_type  odist_ff, odist_in;
   mhs_pkg::pos_type   opos_ff, opos_in;
   mhs_pkg::motif_type omot_ff, omot_in;
   mhs_pkg::total_type ototal_ff, ototal_in;
   logic               ofound_ff, ofound_in;
   logic               olast_ff, olast_in;

   mhs_pkg::dist_type  win_dist;
   mhs_pkg::dist_type  upd_min;
   mhs_pkg::pos_type   upd_pos;
   mhs_pkg::motif_type upd_mot;
   logic               upd_seen;
   logic [mhs_pkg::TOTAL_W:0] sum;
   mhs_pkg::total_type sat_sum;

   always_comb begin
      win_dist = '0;
      for (int k = 0; k < mhs_pkg::MOTIF_LEN; k++) begin
         win_dist = win_dist + mhs_pkg::dist_type'(mism[k]);
      end
   end

   always_comb begin
      upd_min  = min_ff;
      upd_pos  = mpos_ff;
      upd_mot  = mmot_ff;
      upd_seen = seen_ff;
      if (ctrl.win && (!seen_ff || (win_dist < min_ff))) begin
         upd_min  = win_dist;
         upd_pos  = pos;
         upd_mot  = motif;
         upd_seen = 1'b1;
      end
      sum     = {1'b0, total_ff} + (mhs_pkg::TOTAL_W + 1)'(upd_min);
      sat_sum = (sum > {1'b0, mhs_pkg::TOTAL_CAP}) ? mhs_pkg::TOTAL_CAP
                                                   : sum[mhs_pkg::TOTAL_W-1:0];
   end

   always_comb begin
      min_in    = min_ff;
      mpos_in   = mpos_ff;
      mmot_in   = mmot_ff;
      seen_in   = seen_ff;
      total_in  = total_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      odist_in  = odist_ff;
      opos_in   = opos_ff;
      omot_in   = omot_ff;
      ototal_in = ototal_ff;
      ofound_in = ofound_ff;
      olast_in  = olast_ff;
      if (advance) begin
         min_in  = upd_min;
         mpos_in = upd_pos;
         mmot_in = upd_mot;
         seen_in = upd_seen;
         if (ctrl.seq_end) begin
            ovalid_in = 1'b1;
            odist_in  = upd_min;
            opos_in   = upd_pos;
            omot_in   = upd_mot;
            ototal_in = sat_sum;
            ofound_in = upd_seen;
            olast_in  = ctrl.set_end;
            min_in    = mhs_pkg::NO_WINDOW_DIST;
            mpos_in   = '0;
            mmot_in   = '0;
            seen_in   = 1'b0;
            total_in  = ctrl.set_end ? '0 : sat_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= mhs_pkg::NO_WINDOW_DIST;
         mpos_ff   <= '0;
         mmot_ff   <= '0;
         seen_ff   <= 1'b0;
         total_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         min_ff    <= min_in;
         mpos_ff   <= mpos_in;
         mmot_ff   <= mmot_in;
         seen_ff   <= seen_in;
         total_ff  <= total_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      odist_ff  <= odist_in;
      opos_ff   <= opos_in;
      omot_ff   <= omot_in;
      ototal_ff <= ototal_in;
      ofound_ff <= ofound_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid          = ovalid_ff;
   assign rsp_best_distance  = odist_ff;
   assign rsp_best_position  = opos_ff;
   assign rsp_best_motif     = omot_ff;
   assign rsp_total_distance = ototal_ff;
   assign rsp_found          = ofound_ff;
   assign rsp_last           = olast_ff;

endmodule

### rtl/motif_hamming_scanner_core.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner core
// Scans a stream of DNA bases for the window closest to a six-base pattern
// and reports the best window of each sequence with a running set total.
//
//   Channel   Direction  Word contents
//   req_      in         base, end_of_sequence, end_of_set
//   rsp_      out        best_distance, best_position, best_motif,
//                        total_distance, found, last
//   csr_      in         pattern
//
// One base word is accepted per cycle while req_ready is high. The word
// that ends a sequence is registered in the window cell chain and its result
// in the best-window tracker. Reset clears all control and tracking state at
// once. While a result waits in the output register and the word in the cell
// stage also ends a sequence, req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module motif_hamming_scanner_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhs_pkg::base_type   req_base,
   input  logic                req_end_of_sequence,
   input  logic                req_end_of_set,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mhs_pkg::dist_type   rsp_best_distance,
   output mhs_pkg::pos_type    rsp_best_position,
   output mhs_pkg::motif_type  rsp_best_motif,
   output mhs_pkg::total_type  rsp_total_distance,
   output logic                rsp_found,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  mhs_pkg::motif_type  csr_pattern
);

   localparam int L = mhs_pkg::MOTIF_LEN;

   mhs_pkg::motif_type      pattern_ff, pattern_in;
   mhs_pkg::count_type      count_ff, count_in;
   logic                    s1_valid_ff, s1_valid_in;
   mhs_pkg::stage_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   mhs_pkg::pos_type        s1_pos_ff, s1_pos_in;

   logic                    accept;
   logic                    in_range;
   logic                    shift_en;
   logic                    advance;
   logic                    stall;
   mhs_pkg::count_type      pos_full;

   mhs_pkg::base_type       chain [L+1];
   mhs_pkg::motif_type      motif;
   logic [L-1:0]            mism;

   assign csr_ready  = 1'b1;
   assign pattern_in = (csr_valid && csr_ready) ? csr_pattern : pattern_ff;

   assign stall     = s1_valid_ff && s1_ctrl_ff.seq_end && rsp_valid && !rsp_ready;
   assign advance   = s1_valid_ff && !stall;
   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;
   assign in_range  = count_ff < mhs_pkg::count_type'(mhs_pkg::MAX_SEQ_LEN);
   assign shift_en  = accept && in_range;
   assign pos_full  = count_ff - mhs_pkg::count_type'(L - 1);

   always_comb begin
      count_in    = count_ff;
      s1_valid_in = s1_valid_ff && !advance;
      s1_ctrl_in  = s1_ctrl_ff;
      s1_pos_in   = s1_pos_ff;
      if (accept) begin
         s1_valid_in        = 1'b1;
         s1_ctrl_in.win     = in_range && (count_ff >= mhs_pkg::count_type'(L - 1));
         s1_ctrl_in.seq_end = req_end_of_sequence || req_end_of_set;
         s1_ctrl_in.set_end = req_end_of_set;
         s1_pos_in          = pos_full[mhs_pkg::POS_W-1:0];
         if (in_range) begin
            count_in = count_ff + mhs_pkg::count_type'(1);
         end
         if (req_end_of_sequence || req_end_of_set) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s1_ctrl_ff  <= '0;
      end else begin
         pattern_ff  <= pattern_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
         s1_ctrl_ff  <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
   end

   assign chain[L] = req_base;

   for (genvar k = 0; k < L; k++) begin : g_cell
      mhs_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .base_in  (chain[k+1]),
         .want     (pattern_ff[mhs_pkg::CODE_W*(L-1-k) +: mhs_pkg::CODE_W]),
         .base_out (chain[k]),
         .code_out (motif[mhs_pkg::CODE_W*(L-1-k) +: mhs_pkg::CODE_W]),
         .mismatch (mism[k])
      );
   end

   mhs_tracker u_tracker (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .ctrl               (s1_ctrl_ff),
      .pos                (s1_pos_ff),
      .mism               (mism),
      .motif              (motif),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_best_distance  (rsp_best_distance),
      .rsp_best_position  (rsp_best_position),
      .rsp_best_motif     (rsp_best_motif),
      .rsp_total_distance (rsp_total_distance),
      .rsp_found          (rsp_found),
      .rsp_last           (rsp_last)
   );

   a_no_window_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_best_distance == mhs_pkg::NO_WINDOW_DIST && rsp_best_position == '0 &&
         rsp_best_motif == '0)
      else $error("Result without a full window carries window data.");

   a_total_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_distance <= mhs_pkg::TOTAL_CAP)
      else $error("Set total exceeds its saturation limit.");

   a_end_held: assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && s1_ctrl_ff.seq_end && $stable(s1_pos_ff))
      else $error("Sequence end word left the cell stage while the result was blocked.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mhs_pkg::count_type'(mhs_pkg::MAX_SEQ_LEN))
      else $error("Base count ran past the sequence length limit.");

endmodule

### bench/mhs_checker.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner result checker
// Watches the base, result and pattern channels of the scanner at the rising
// clock edge. Every accepted base word advances a local model of the window
// and best-window tracker. Every sequence or set end queues the expected
// result. Each accepted result word is compared field by field with the oldest
// entry in that queue. The failure count and the number of outstanding
// results go back to the testbench top.
// ----------------------------------------------------------------------------
module mhs_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  mhs_pkg::base_type   req_base,
   input  logic                req_end_of_sequence,
   input  logic                req_end_of_set,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  mhs_pkg::dist_type   rsp_best_distance,
   input  mhs_pkg::pos_type    rsp_best_position,
   input  mhs_pkg::motif_type  rsp_best_motif,
   input  mhs_pkg::total_type  rsp_total_distance,
   input  logic                rsp_found,
   input  logic                rsp_last,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  mhs_pkg::motif_type  csr_pattern,
   output int                  fail_count,
   output int                  pending_count
);

   typedef struct packed {
      mhs_pkg::dist_type  distance;
      mhs_pkg::pos_type   position;
      mhs_pkg::motif_type motif;
      mhs_pkg::total_type total;
      logic               found;
      logic               last;
   } scan_result_type;

   scan_result_type best_window_q[$];

   mhs_pkg::motif_type pattern;
   mhs_pkg::base_type  window_bases[mhs_pkg::MOTIF_LEN];
   mhs_pkg::count_type base_count;
   mhs_pkg::dist_type  min_dist;
   mhs_pkg::pos_type   min_pos;
   mhs_pkg::motif_type min_motif;
   int                 running_total;
   logic               window_seen;

   task automatic clear_sequence();
      for (int k = 0; k < mhs_pkg::MOTIF_LEN; k++) begin
         window_bases[k] = '0;
      end
      base_count  = '0;
      min_dist    = mhs_pkg::NO_WINDOW_DIST;
      min_pos     = '0;
      min_motif   = '0;
      window_seen = 1'b0;
   endtask

   task automatic report_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", what);
      end
   endtask

   task automatic scan_base(input mhs_pkg::base_type b, input logic seq_end,
                            input logic set_end);
      int                 miss_count;
      mhs_pkg::motif_type motif;
      mhs_pkg::code_type  want;
      logic               other;
      scan_result_type    res;
      if (base_count < mhs_pkg::MAX_SEQ_LEN) begin
         for (int k = 0; k < mhs_pkg::MOTIF_LEN - 1; k++) begin
            window_bases[k] = window_bases[k + 1];
         end
         window_bases[mhs_pkg::MOTIF_LEN - 1] = b;
         base_count++;
         if (base_count >= mhs_pkg::MOTIF_LEN) begin
            miss_count = 0;
            motif      = '0;
            for (int k = 0; k < mhs_pkg::MOTIF_LEN; k++) begin
               want  = pattern[mhs_pkg::CODE_W * (mhs_pkg::MOTIF_LEN - 1 - k)
                               +: mhs_pkg::CODE_W];
               other = window_bases[k][mhs_pkg::BASE_W - 1];
               if (other || window_bases[k][mhs_pkg::CODE_W - 1:0] != want) begin
                  miss_count++;
               end
               motif = {motif[mhs_pkg::MOTIF_W - mhs_pkg::CODE_W - 1:0],
                        other ? mhs_pkg::code_type'(0)
                              : window_bases[k][mhs_pkg::CODE_W - 1:0]};
            end
            if (!window_seen || miss_count < min_dist) begin
               min_dist    = mhs_pkg::dist_type'(miss_count);
               min_pos     = mhs_pkg::pos_type'(base_count - mhs_pkg::MOTIF_LEN);
               min_motif   = motif;
               window_seen = 1'b1;
            end
         end
      end
      if (seq_end || set_end) begin
         running_total += min_dist;
         if (running_total > mhs_pkg::TOTAL_CAP) begin
            running_total = mhs_pkg::TOTAL_CAP;
         end
         res.distance = min_dist;
         res.position = min_pos;
         res.motif    = min_motif;
         res.total    = mhs_pkg::total_type'(running_total);
         res.found    = window_seen;
         res.last     = set_end;
         best_window_q = {best_window_q, res};
         clear_sequence();
         if (set_end) begin
            running_total = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      scan_result_type want_res;
      if (reset) begin
         pattern       = '0;
         running_total = 0;
         clear_sequence();
         best_window_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (best_window_q.size() == 0) begin
               report_failure($sformatf(
                  "unexpected result word: dist %0d pos %0d motif %03h total %0d found %0b last %0b",
                  rsp_best_distance, rsp_best_position, rsp_best_motif,
                  rsp_total_distance, rsp_found, rsp_last));
            end else begin
               want_res = best_window_q.pop_front();
               if (rsp_best_distance !== want_res.distance
                   || rsp_best_position !== want_res.position
                   || rsp_best_motif !== want_res.motif
                   || rsp_total_distance !== want_res.total
                   || rsp_found !== want_res.found
                   || rsp_last !== want_res.last) begin
                  report_failure($sformatf(
                     {"result mismatch: expected dist %0d pos %0d motif %03h total %0d",
                      " found %0b last %0b, got dist %0d pos %0d motif %03h total %0d",
                      " found %0b last %0b"},
                     want_res.distance, want_res.position, want_res.motif,
                     want_res.total, want_res.found, want_res.last,
                     rsp_best_distance, rsp_best_position, rsp_best_motif,
                     rsp_total_distance, rsp_found, rsp_last));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            pattern = csr_pattern;
         end
         if (req_valid && req_ready) begin
            scan_base(req_base, req_end_of_sequence, req_end_of_set);
         end
      end
      pending_count = best_window_q.size();
   end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Motif Hamming scanner testbench
// Drives base words, pattern writes and result back-pressure into the
// scanner core and leaves all prediction and comparison to the checker.
// A short directed run covers exact matches, short sequences, distance ties,
// unknown bases and set ends without a sequence end. Then come a run that
// saturates the set total and random sets under several patterns, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam mhs_pkg::base_type BASE_A     = 3'd0;
   localparam mhs_pkg::base_type BASE_C     = 3'd1;
   localparam mhs_pkg::base_type BASE_G     = 3'd2;
   localparam mhs_pkg::base_type BASE_T     = 3'd3;
   localparam mhs_pkg::base_type OTHER_BASE = 3'd4;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   mhs_pkg::base_type  req_base;
   logic               req_end_of_sequence;
   logic               req_end_of_set;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   mhs_pkg::dist_type  rsp_best_distance;
   mhs_pkg::pos_type   rsp_best_position;
   mhs_pkg::motif_type rsp_best_motif;
   mhs_pkg::total_type rsp_total_distance;
   logic               rsp_found;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   mhs_pkg::motif_type csr_pattern;

   int                 fail_count;
   int                 pending_count;
   int                 sent_items = 0;
   int                 stall_left = 0;
   bit                 full_speed_in = 1'b0;
   bit                 full_speed_out = 1'b0;
   mhs_pkg::motif_type current_pattern = '0;

   motif_hamming_scanner_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_base            (req_base),
      .req_end_of_sequence (req_end_of_sequence),
      .req_end_of_set      (req_end_of_set),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_distance   (rsp_best_distance),
      .rsp_best_position   (rsp_best_position),
      .rsp_best_motif      (rsp_best_motif),
      .rsp_total_distance  (rsp_total_distance),
      .rsp_found           (rsp_found),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_pattern         (csr_pattern)
   );

   mhs_checker result_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_base            (req_base),
      .req_end_of_sequence (req_end_of_sequence),
      .req_end_of_set      (req_end_of_set),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_best_distance   (rsp_best_distance),
      .rsp_best_position   (rsp_best_position),
      .rsp_best_motif      (rsp_best_motif),
      .rsp_total_distance  (rsp_total_distance),
      .rsp_found           (rsp_found),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_pattern         (csr_pattern),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #48_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int gap_length(input bit no_idle);
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic mhs_pkg::base_type random_base();
      if ($urandom_range(0, 9) == 0) begin
         return OTHER_BASE;
      end
      return mhs_pkg::base_type'($urandom_range(0, 3));
   endfunction

   function automatic int random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return $urandom_range(1, 5);
      end else if (r < 85) begin
         return $urandom_range(6, 24);
      end else if (r < 97) begin
         return $urandom_range(25, 80);
      end
      return $urandom_range(100, 300);
   endfunction

   // The result side stalls on its own schedule, with bursts of full speed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 19) == 0) begin
            full_speed_out = !full_speed_out;
         end
         stall_left = gap_length(full_speed_out);
      end
   end

   task automatic send_word(input mhs_pkg::base_type b, input logic seq_end,
                            input logic set_end);
      int g;
      req_valid           <= 1'b1;
      req_base            <= b;
      req_end_of_sequence <= seq_end;
      req_end_of_set      <= set_end;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      @(negedge clock);
      g = gap_length(full_speed_in);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic send_bases(input mhs_pkg::base_type bases[$], input logic seq_end,
                             input logic set_end);
      int last_idx;
      last_idx = bases.size() - 1;
      for (int i = 0; i <= last_idx; i++) begin
         send_word(bases[i], seq_end && i == last_idx, set_end && i == last_idx);
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_pattern(input mhs_pkg::motif_type value);
      hold_until_drained();
      repeat (4) @(negedge clock);
      csr_valid   <= 1'b1;
      csr_pattern <= value;
      do @(posedge clock); while (!csr_ready);
      current_pattern = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A sequence of random bases, often with a copy of the pattern planted in it.
   task automatic send_random_sequence(input int len, input bit close_set);
      mhs_pkg::base_type bases[$];
      int                plant_at;
      int                k;
      plant_at = -1;
      if (len >= mhs_pkg::MOTIF_LEN && $urandom_range(0, 9) < 4) begin
         plant_at = $urandom_range(0, len - mhs_pkg::MOTIF_LEN);
      end
      for (int i = 0; i < len; i++) begin
         k = i - plant_at;
         if (plant_at >= 0 && k >= 0 && k < mhs_pkg::MOTIF_LEN
             && $urandom_range(0, 9) != 0) begin
            bases = {bases, mhs_pkg::base_type'(current_pattern[
                       mhs_pkg::CODE_W * (mhs_pkg::MOTIF_LEN - 1 - k) +: mhs_pkg::CODE_W])};
         end else begin
            bases = {bases, random_base()};
         end
      end
      if (close_set) begin
         send_bases(bases, $urandom_range(0, 3) != 0, 1'b1);
      end else begin
         send_bases(bases, 1'b1, 1'b0);
      end
   endtask

   initial begin
      int set_size;
      int start_items;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_base            = '0;
      req_end_of_sequence = 1'b0;
      req_end_of_set      = 1'b0;
      csr_valid           = 1'b0;
      csr_pattern         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The pattern is ACGTAC.
      write_pattern(12'b00_01_10_11_00_01);
      send_bases('{BASE_A, BASE_C, BASE_G, BASE_T, BASE_A, BASE_C}, 1'b1, 1'b0);
      send_bases('{BASE_C, BASE_G}, 1'b1, 1'b0);
      send_bases('{OTHER_BASE, OTHER_BASE, OTHER_BASE, OTHER_BASE, OTHER_BASE,
                   OTHER_BASE, OTHER_BASE}, 1'b1, 1'b0);
      send_bases('{BASE_T, BASE_T, BASE_A, BASE_C, BASE_G, BASE_T, BASE_A, BASE_C},
                 1'b1, 1'b0);
      send_bases('{BASE_G}, 1'b1, 1'b1);
      send_bases('{BASE_T}, 1'b0, 1'b1);

      // Enough short sequences to drive the set total into saturation.
      write_pattern('0);
      for (int i = 0; i < mhs_pkg::MAX_SEQUENCES + 4; i++) begin
         send_bases('{random_base()}, 1'b1, i == mhs_pkg::MAX_SEQUENCES + 3);
      end
      send_bases('{BASE_A, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A}, 1'b1, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         write_pattern(mhs_pkg::motif_type'($urandom_range(0, 4095)));
         start_items = sent_items;
         while (sent_items - start_items < 300) begin
            set_size = $urandom_range(1, 8);
            for (int s = 0; s < set_size; s++) begin
               if ($urandom_range(0, 4) == 0) begin
                  full_speed_in = !full_speed_in;
               end
               send_random_sequence(random_length(), s == set_size - 1);
               if ($urandom_range(0, 24) == 0) begin
                  hold_until_drained();
               end
            end
         end
      end

      hold_until_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### motif_hamming_scanner_core.f
rtl/mhs_pkg.sv
rtl/mhs_cell.sv
rtl/mhs_tracker.sv
rtl/motif_hamming_scanner_core.sv
bench/mhs_checker.sv
bench/tb.sv
